### rtl/nnis_pkg.sv
package nnis_pkg;

   localparam int PIXEL_W     = 32;
   localparam int ADDR_W      = 16;
   localparam int SRC_BUFFER_PIXELS = 65536;
   localparam int SRC_SIZE_W  = 9;
   localparam int DST_SIZE_W  = 13;
   localparam int SRC_IDX_W   = 8;
   localparam int DST_CNT_W   = 12;
   localparam int PROD_W      = DST_CNT_W + SRC_SIZE_W;
   localparam int BASE_W      = SRC_IDX_W + SRC_SIZE_W;
   localparam int DIV_CNT_W   = $clog2(PROD_W + 1);

   localparam logic [SRC_SIZE_W-1:0] MAX_SRC_WIDTH  = 9'd256;
   localparam logic [SRC_SIZE_W-1:0] MAX_SRC_HEIGHT = 9'd256;
   localparam logic [DST_SIZE_W-1:0] MAX_DST_SIDE   = 13'd4096;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_EMIT = 1'b1;

   // sizes after clamping to their legal ranges
   typedef struct packed {
      logic [SRC_SIZE_W-1:0] src_width;
      logic [SRC_SIZE_W-1:0] src_height;
      logic [DST_SIZE_W-1:0] dst_width;
      logic [DST_SIZE_W-1:0] dst_height;
   } cfg_type;

endpackage

### rtl/nearest_neighbor_image_scaler_top.sv
// Channel | Direction | Transfer
// req     | in        | tdata = {load_pixel, load_index}, tuser = action
// rsp     | out       | tdata = out_pixel, tlast = row_end, tuser = frame_end
// csr     | in/out    | APB-style, four size registers at 0x0, 0x4, 0x8, 0xC
//
// A load writes the pixel into the frame store on transfer.
// An emit runs two 21-step serial dividers that map the destination
// column and row, then row base, store read and output register follow.
// Reset is synchronous; the frame store is not cleared.
// A stalled rsp holds the block before its next req transfer.
module nearest_neighbor_image_scaler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // load_index[15:0], load_pixel[47:16]
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_pixel[31:0]
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // frame_end
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import nnis_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_START  = 6'b000010,
      ST_DIVIDE = 6'b000100,
      ST_BASE   = 6'b001000,
      ST_READ   = 6'b010000,
      ST_OUTPUT = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   cfg_type               cfg;

   logic [DST_CNT_W-1:0]  dest_col_ff, dest_col_in;
   logic [DST_CNT_W-1:0]  dest_row_ff, dest_row_in;
   logic [PROD_W-1:0]     col_prod_ff, row_prod_ff;
   logic                  row_end_ff, frame_end_ff;
   logic [BASE_W-1:0]     base_ff;
   logic [SRC_IDX_W-1:0]  src_col_ff;
   logic                  rsp_valid_ff;
   logic [PIXEL_W-1:0]    rsp_pixel_ff;
   logic                  rsp_row_end_ff, rsp_frame_end_ff;

   logic                  req_fire, emit_fire, load_fire;
   logic                  rend, fend;
   logic                  div_start, col_busy, row_busy;
   logic [SRC_IDX_W-1:0]  col_q, row_q;
   logic [SRC_IDX_W-1:0]  col_limit, row_limit;
   logic [BASE_W-1:0]     rd_sum;
   logic [PIXEL_W-1:0]    rd_data;
   logic                  out_free;

   nnis_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid & req_tready;
   assign emit_fire  = req_fire & (req_tuser == ACTION_EMIT);
   assign load_fire  = req_fire & (req_tuser == ACTION_LOAD);

   // a counter at or past the last position counts as the last one
   assign rend = {1'b0, dest_col_ff} >= (cfg.dst_width - DST_SIZE_W'(1));
   assign fend = rend & ({1'b0, dest_row_ff} >= (cfg.dst_height - DST_SIZE_W'(1)));

   always_comb begin
      dest_col_in = dest_col_ff;
      dest_row_in = dest_row_ff;
      if (emit_fire) begin
         if (fend) begin
            dest_col_in = '0;
            dest_row_in = '0;
         end else if (rend) begin
            dest_col_in = '0;
            dest_row_in = dest_row_ff + DST_CNT_W'(1);
         end else begin
            dest_col_in = dest_col_ff + DST_CNT_W'(1);
         end
      end
   end

   assign div_start = state_ff == ST_START;
   assign col_limit = SRC_IDX_W'(cfg.src_width - SRC_SIZE_W'(1));
   assign row_limit = SRC_IDX_W'(cfg.src_height - SRC_SIZE_W'(1));

   nnis_div u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (col_prod_ff),
      .divisor  (cfg.dst_width),
      .limit    (col_limit),
      .busy     (col_busy),
      .quotient (col_q)
   );

   nnis_div u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (row_prod_ff),
      .divisor  (cfg.dst_height),
      .limit    (row_limit),
      .busy     (row_busy),
      .quotient (row_q)
   );

   assign rd_sum = base_ff + BASE_W'(src_col_ff);

   nnis_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (SRC_BUFFER_PIXELS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (req_tdata[ADDR_W-1:0]),
      .wr_data (req_tdata[ADDR_W+PIXEL_W-1:ADDR_W]),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (rd_sum[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (emit_fire) state_in = ST_START;
         ST_START:  state_in = ST_DIVIDE;
         ST_DIVIDE: if (!col_busy && !row_busy) state_in = ST_BASE;
         ST_BASE:   state_in = ST_READ;
         ST_READ:   state_in = ST_OUTPUT;
         ST_OUTPUT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dest_col_ff  <= '0;
         dest_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         dest_col_ff <= dest_col_in;
         dest_row_ff <= dest_row_in;
         if (state_ff == ST_OUTPUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         col_prod_ff  <= PROD_W'(dest_col_ff) * PROD_W'(cfg.src_width);
         row_prod_ff  <= PROD_W'(dest_row_ff) * PROD_W'(cfg.src_height);
         row_end_ff   <= rend;
         frame_end_ff <= fend;
      end
      if (state_ff == ST_DIVIDE) begin
         base_ff    <= BASE_W'(row_q) * BASE_W'(cfg.src_width);
         src_col_ff <= col_q;
      end
      if (state_ff == ST_OUTPUT && out_free) begin
         rsp_pixel_ff     <= rd_data;
         rsp_row_end_ff   <= row_end_ff;
         rsp_frame_end_ff <= frame_end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_row_end_ff;
   assign rsp_tuser  = rsp_frame_end_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_frame_end_ff || rsp_row_end_ff))
      else $error("frame end without row end");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!col_busy && !row_busy))
      else $error("divider busy while idle");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && fend) |=> (dest_col_ff == '0 && dest_row_ff == '0))
      else $error("destination counters did not wrap at frame end");

endmodule

### rtl/nnis_ram.sv
module nnis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/nnis_csr.sv
module nnis_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output nnis_pkg::cfg_type cfg
);
   import nnis_pkg::*;

   localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
   localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

   logic [SRC_SIZE_W-1:0] src_width_ff,  src_height_ff;
   logic [DST_SIZE_W-1:0] dst_width_ff,  dst_height_ff;
   logic                  wr_en;
   logic [1:0]            reg_idx;

   function automatic logic [SRC_SIZE_W-1:0] clamp_src(input logic [SRC_SIZE_W-1:0] v,
                                                       input logic [SRC_SIZE_W-1:0] maxv);
      logic [SRC_SIZE_W-1:0] r;
      if (v == '0) r = SRC_SIZE_W'(1);
      else if (v > maxv) r = maxv;
      else r = v;
      return r;
   endfunction

   function automatic logic [DST_SIZE_W-1:0] clamp_dst(input logic [DST_SIZE_W-1:0] v);
      logic [DST_SIZE_W-1:0] r;
      if (v == '0) r = DST_SIZE_W'(1);
      else if (v > MAX_DST_SIDE) r = MAX_DST_SIDE;
      else r = v;
      return r;
   endfunction

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 9'd256;
         src_height_ff <= 9'd256;
         dst_width_ff  <= 13'd256;
         dst_height_ff <= 13'd256;
      end else if (wr_en) begin
         case (reg_idx)
            REG_SRC_WIDTH:  src_width_ff  <= csr_pwdata[SRC_SIZE_W-1:0];
            REG_SRC_HEIGHT: src_height_ff <= csr_pwdata[SRC_SIZE_W-1:0];
            REG_DST_WIDTH:  dst_width_ff  <= csr_pwdata[DST_SIZE_W-1:0];
            REG_DST_HEIGHT: dst_height_ff <= csr_pwdata[DST_SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SRC_WIDTH:  csr_prdata = 32'(src_width_ff);
         REG_SRC_HEIGHT: csr_prdata = 32'(src_height_ff);
         REG_DST_WIDTH:  csr_prdata = 32'(dst_width_ff);
         REG_DST_HEIGHT: csr_prdata = 32'(dst_height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.src_width  = clamp_src(src_width_ff, MAX_SRC_WIDTH);
   assign cfg.src_height = clamp_src(src_height_ff, MAX_SRC_HEIGHT);
   assign cfg.dst_width  = clamp_dst(dst_width_ff);
   assign cfg.dst_height = clamp_dst(dst_height_ff);

endmodule

### rtl/nnis_div.sv
module nnis_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [nnis_pkg::PROD_W-1:0]    dividend,
   input  logic [nnis_pkg::DST_SIZE_W-1:0] divisor,
   input  logic [nnis_pkg::SRC_IDX_W-1:0] limit,
   output logic                           busy,
   output logic [nnis_pkg::SRC_IDX_W-1:0] quotient
);
   import nnis_pkg::*;

   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DST_SIZE_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [DST_SIZE_W:0]   trial;
   logic [DST_SIZE_W:0]   diff;
   logic                  ge;

   // restoring division: one quotient bit per cycle, shifted into acc
   assign trial = {rem_ff, acc_ff[PROD_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign ge    = trial >= {1'b0, divisor};
   assign busy  = cnt_ff != '0;

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      acc_in = acc_ff;
      if (start) begin
         cnt_in = DIV_CNT_W'(PROD_W);
         rem_in = '0;
         acc_in = dividend;
      end else if (busy) begin
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         rem_in = ge ? diff[DST_SIZE_W-1:0] : trial[DST_SIZE_W-1:0];
         acc_in = {acc_ff[PROD_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   // saturate at the last source position
   assign quotient = (acc_ff > PROD_W'(limit)) ? limit : acc_ff[SRC_IDX_W-1:0];

endmodule
